>>> rtl/twma_pkg.sv
package twma_pkg;

    // field widths of the words on the channels
    localparam int TIME_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int WIN_W     = 10;
    localparam int WORD_W    = TIME_W + SAMPLE_W;
    localparam int DEPTH_DEF = 64;

    // window length after reset, in ms
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(200);

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic rd_oldest;
        logic rd_newest;
        logic drop;
        logic replace;
        logic append;
        logic div_start;
        logic out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic too_old;
        logic same_time;
        logic div_done;
    } t_dp_stat;

endpackage

>>> rtl/time_window_moving_average.sv
// channel  | valid        | ready        | word
// ---------+--------------+--------------+----------------------------------
// input    | i_valid      | o_ready      | i_timestamp_ms, i_sample
// result   | o_valid      | i_ready      | o_mean, o_entries_held
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_data (window_ms)
//
// one word at a time; SW is the sum width (22 at depth 64). the eviction loop
// reads the oldest entry through the ring's registered read port, and the
// restoring divider yields one quotient bit per cycle. a full ring drops its
// oldest entry before the append, a same-stamp word overwrites the newest
// entry, and a ring emptied by eviction skips the newest-entry read. the next
// word can be taken in the cycle after the result is loaded. reset clears
// pointers, count and sum and sets the window to 200 ms; the ring contents
// need no clearing. a stalled result waits in the output register while the
// next word is taken in.
module time_window_moving_average
    import twma_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [TIME_W-1:0]            i_timestamp_ms,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SAMPLE_W-1:0]   o_mean,
    output logic [$clog2(DEPTH+1)-1:0]   o_entries_held,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [WIN_W-1:0]             i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // window register takes a write at any time
    assign o_cfg_ready = 1'b1;

    twma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    twma_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_timestamp_ms (i_timestamp_ms),
        .i_sample       (i_sample),
        .o_mean         (o_mean),
        .o_entries_held (o_entries_held)
    );

endmodule

>>> rtl/twma_ram.sv
module twma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/twma_div.sv
module twma_div #(
    parameter int SW = 22,
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_dividend,
    input  logic [CW-1:0]        i_divisor,
    output logic                 o_done,
    output logic signed [SW-1:0] o_quotient
);

    localparam int NW = $clog2(SW + 1);

    logic [NW-1:0] r_cnt;
    logic          r_done;
    logic          r_neg;
    logic [SW-1:0] r_quo;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;

    logic [CW:0]   shifted;
    logic          fits;
    logic [CW-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {r_rem, r_quo[SW-1]};
        fits    = shifted >= {1'b0, r_div};
        if (fits) begin
            n_rem = CW'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[CW-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= NW'(SW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude division, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SW-1];
            r_quo <= i_dividend[SW-1] ? SW'(-i_dividend) : SW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[SW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

>>> rtl/twma_dp.sv
module twma_dp
    import twma_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic                         i_cfg_we,
    input  logic [WIN_W-1:0]             i_cfg_data,
    input  logic [TIME_W-1:0]            i_timestamp_ms,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic signed [SAMPLE_W-1:0]   o_mean,
    output logic [$clog2(DEPTH+1)-1:0]   o_entries_held
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = SAMPLE_W + IW;

    logic [WIN_W-1:0]           r_window;
    logic [TIME_W-1:0]          r_now;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [IW-1:0]              r_oldest;
    logic [CW-1:0]              r_count;
    logic signed [SW-1:0]       r_sum;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [CW-1:0]              r_held;

    logic [WORD_W-1:0]          rdata;
    logic [TIME_W-1:0]          rtime;
    logic signed [SW-1:0]       rvalue;
    logic signed [SW-1:0]       sample_ext;
    logic [IW-1:0]              newest;
    logic [IW-1:0]              slot;
    logic [IW-1:0]              raddr;
    logic [IW-1:0]              waddr;
    logic                       div_done;
    logic signed [SW-1:0]       quotient;

    // ring position base + off, both below the depth
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] p;
        p = {1'b0, base} + {1'b0, off};
        if (p >= (IW+1)'(DEPTH)) begin
            p = p - (IW+1)'(DEPTH);
        end
        return p[IW-1:0];
    endfunction

    // fields of the word read back from the ring
    assign rtime      = rdata[WORD_W-1:SAMPLE_W];
    assign rvalue     = {{IW{rdata[SAMPLE_W-1]}}, rdata[SAMPLE_W-1:0]};
    assign sample_ext = {{IW{r_sample[SAMPLE_W-1]}}, r_sample};

    // ring positions of the newest entry and of the next free slot
    assign newest = ring_add(r_oldest, IW'(r_count - CW'(1)));
    assign slot   = ring_add(r_oldest, r_count[IW-1:0]);
    assign raddr  = i_cmd.rd_newest ? newest : r_oldest;
    assign waddr  = i_cmd.replace ? newest : slot;

    twma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.replace | i_cmd.append),
        .i_waddr (waddr),
        .i_wdata ({r_now, r_sample}),
        .i_re    (i_cmd.rd_oldest | i_cmd.rd_newest),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    twma_div #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // status back to the controller
    always_comb begin
        o_stat.count_zero = r_count == '0;
        o_stat.count_full = r_count == CW'(DEPTH);
        o_stat.too_old    = ({1'b0, rtime} + (TIME_W+1)'(r_window)) < {1'b0, r_now};
        o_stat.same_time  = rtime == r_now;
        o_stat.div_done   = div_done;
    end

    // window register and ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_oldest <= '0;
            r_count  <= '0;
            r_sum    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.drop) begin
                r_sum    <= r_sum - rvalue;
                r_oldest <= ring_add(r_oldest, IW'(1));
                r_count  <= r_count - CW'(1);
            end else if (i_cmd.replace) begin
                r_sum <= r_sum - rvalue + sample_ext;
            end else if (i_cmd.append) begin
                r_sum   <= r_sum + sample_ext;
                r_count <= r_count + CW'(1);
            end
        end
    end

    // input capture and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now    <= i_timestamp_ms;
            r_sample <= i_sample;
        end
        if (i_cmd.out_load) begin
            r_mean <= quotient[SAMPLE_W-1:0];
            r_held <= r_count;
        end
    end

    assign o_mean         = r_mean;
    assign o_entries_held = r_held;

endmodule

>>> rtl/twma_ctrl.sv
module twma_ctrl
    import twma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_RD,
        S_EV_CMP,
        S_NW_RD,
        S_NW_CMP,
        S_FL_RD,
        S_FL_CMP,
        S_APPEND,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EV_RD;
                end
            end
            S_EV_RD: begin
                if (i_stat.count_zero) begin
                    n_state = S_NW_RD;
                end else begin
                    o_cmd.rd_oldest = 1'b1;
                    n_state         = S_EV_CMP;
                end
            end
            S_EV_CMP: begin
                if (i_stat.too_old) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_EV_RD;
                end else begin
                    n_state = S_NW_RD;
                end
            end
            S_NW_RD: begin
                if (i_stat.count_zero) begin
                    n_state = S_APPEND;
                end else begin
                    o_cmd.rd_newest = 1'b1;
                    n_state         = S_NW_CMP;
                end
            end
            S_NW_CMP: begin
                priority if (i_stat.same_time) begin
                    o_cmd.replace = 1'b1;
                    n_state       = S_DIV_GO;
                end else if (i_stat.count_full) begin
                    n_state = S_FL_RD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_FL_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state         = S_FL_CMP;
            end
            S_FL_CMP: begin
                o_cmd.drop = 1'b1;
                n_state    = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_DIV_GO;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
